FILE: rtl/sync_hunt_image_deframer_assert.svh
// ----------------------------------------------------------------------------
// sync_hunt_image_deframer_assert
// Assertion macros used by the deframer top module.
// ----------------------------------------------------------------------------
// Both macros sample on the rising edge of clk_i.
`ifndef SYNC_HUNT_IMAGE_DEFRAMER_ASSERT_SVH
`define SYNC_HUNT_IMAGE_DEFRAMER_ASSERT_SVH

// The property is checked only outside reset.
`define SHID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The property is checked at every edge, during reset as well.
`define SHID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/shid_pkg.sv
// ----------------------------------------------------------------------------
// shid_pkg
// Types and constants of the sync-hunting image deframer.
// ----------------------------------------------------------------------------
package shid_pkg;

  localparam int unsigned SYNC_LENGTH = 64;
  localparam int unsigned SYNC_RUN_W  = $clog2(SYNC_LENGTH + 1);
  localparam logic [7:0]  SYNC_BYTE   = 8'h7A;

  localparam int unsigned HEAD_WORDS = 6;
  localparam logic [4:0]  HEAD_BYTES = 5'(HEAD_WORDS * 4);
  localparam logic [4:0]  HEAD_LAST  = 5'(HEAD_WORDS * 4 - 1);

  localparam int unsigned PIX_CNT_W      = 25;
  localparam logic [24:0] MAX_PIXELS_RST = 25'd4194304;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_PIX  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    phase_e                         phase;
    logic [SYNC_RUN_W-1:0]          sync_run;
    logic [4:0]                     head_idx;
    logic [HEAD_WORDS-1:0][31:0]    words;
    logic [PIX_CNT_W-1:0]           pixels_left;
    logic [7:0]                     low_hold;
    logic                           byte_phase;
  } state_t;

  typedef struct packed {
    kind_e                          kind;
    logic [HEAD_WORDS-1:0][31:0]    words;
    logic [15:0]                    pixel;
    logic                           last;
  } result_t;

endpackage

FILE: rtl/shid_step.sv
// ----------------------------------------------------------------------------
// shid_step
// Next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module shid_step (
  input  shid_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  input  logic [24:0]       max_pixels_i,
  output shid_pkg::state_t  state_o,
  output logic              res_valid_o,
  output shid_pkg::result_t res_o
);

  always_comb begin
    logic [4:0]                          idx;
    logic [31:0]                         cnt;
    logic [shid_pkg::SYNC_RUN_W-1:0]     run_inc;
    logic [shid_pkg::PIX_CNT_W-1:0]      left;

    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    idx         = state_i.head_idx;
    cnt         = '0;
    run_inc     = state_i.sync_run + 1'b1;
    left        = state_i.pixels_left;

    case (state_i.phase)
      shid_pkg::PH_HEAD: begin
        if (idx >= shid_pkg::HEAD_BYTES) begin
          idx = '0;
        end
        for (int w = 0; w < shid_pkg::HEAD_WORDS; w++) begin
          for (int b = 0; b < 4; b++) begin
            if (idx[4:2] == 3'(w) && idx[1:0] == 2'(b)) begin
              state_o.words[w][8*b +: 8] = byte_i;
            end
          end
        end
        if (idx == shid_pkg::HEAD_LAST) begin
          state_o.head_idx = '0;
          cnt              = state_o.words[2];
          res_valid_o      = 1'b1;
          res_o.words      = state_o.words;
          if (cnt[31] || cnt > {7'b0, max_pixels_i}) begin
            res_o.kind       = shid_pkg::KIND_REJECT;
            res_o.last       = 1'b1;
            state_o.phase    = shid_pkg::PH_HUNT;
            state_o.sync_run = '0;
          end else if (cnt == '0) begin
            res_o.kind       = shid_pkg::KIND_HEADER;
            res_o.last       = 1'b1;
            state_o.phase    = shid_pkg::PH_HUNT;
            state_o.sync_run = '0;
          end else begin
            res_o.kind          = shid_pkg::KIND_HEADER;
            res_o.last          = 1'b0;
            state_o.pixels_left = cnt[shid_pkg::PIX_CNT_W-1:0];
            state_o.byte_phase  = 1'b0;
            state_o.phase       = shid_pkg::PH_PIX;
          end
        end else begin
          state_o.head_idx = idx + 1'b1;
        end
      end
      shid_pkg::PH_PIX: begin
        if (!state_i.byte_phase) begin
          state_o.low_hold   = byte_i;
          state_o.byte_phase = 1'b1;
        end else begin
          state_o.byte_phase = 1'b0;
          if (left != '0) begin
            left = left - 1'b1;
          end
          state_o.pixels_left = left;
          res_valid_o         = 1'b1;
          res_o.kind          = shid_pkg::KIND_PIXEL;
          res_o.pixel         = {byte_i, state_i.low_hold};
          res_o.last          = (left == '0);
          if (left == '0) begin
            state_o.phase    = shid_pkg::PH_HUNT;
            state_o.sync_run = '0;
          end
        end
      end
      default: begin
        state_o.phase = shid_pkg::PH_HUNT;
        if (byte_i == shid_pkg::SYNC_BYTE) begin
          if (run_inc >= shid_pkg::SYNC_RUN_W'(shid_pkg::SYNC_LENGTH)) begin
            state_o.sync_run = '0;
            state_o.head_idx = '0;
            state_o.phase    = shid_pkg::PH_HEAD;
          end else begin
            state_o.sync_run = run_inc;
          end
        end else begin
          state_o.sync_run = '0;
        end
      end
    endcase
  end

endmodule

FILE: rtl/sync_hunt_image_deframer.sv
// An accepted byte goes to the input register, and its result to the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the single
// step of logic between the input register and the output register.
// Reset: all frame state clears to hunting, max_pixels returns to 4194304.
// ----------------------------------------------------------------------------
// sync_hunt_image_deframer
// Hunts for a run of sync bytes, then emits the header or reject record and the pixels
// of each frame.
// ----------------------------------------------------------------------------
module sync_hunt_image_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] size_x_o,
  output logic signed [31:0] size_y_o,
  output logic signed [31:0] pixel_count_o,
  output logic signed [31:0] frame_id_o,
  output logic signed [31:0] image_count_o,
  output logic signed [31:0] error_word_o,
  output logic [15:0]        pixel_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "sync_hunt_image_deframer_assert.svh"

  localparam logic REG_MAX_PIXELS = 1'b0;

  logic              in_v_q;
  logic [7:0]        in_byte_q;
  logic [24:0]       max_pix_q;
  shid_pkg::state_t  state_q;
  shid_pkg::state_t  state_d;
  logic              res_valid;
  shid_pkg::result_t res;
  logic              out_v_q;
  shid_pkg::result_t out_q;
  logic              fire;
  logic              in_acc;
  logic              cfg_wr;

  shid_step u_step (
    .state_i      (state_q),
    .byte_i       (in_byte_q),
    .max_pixels_i (max_pix_q),
    .state_o      (state_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign fire       = in_v_q && (!res_valid || !out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PIXELS) ? {7'b0, max_pix_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      max_pix_q <= shid_pkg::MAX_PIXELS_RST;
      state_q   <= '{phase: shid_pkg::PH_HUNT, default: '0};
    end else begin
      if (in_acc) begin
        in_v_q <= 1'b1;
      end else if (fire) begin
        in_v_q <= 1'b0;
      end
      if (fire) begin
        state_q <= state_d;
      end
      if (fire && res_valid) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_wr && paddr[2] == REG_MAX_PIXELS) begin
        max_pix_q <= pwdata[24:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= byte_in_i;
    end
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_q.kind;
  assign size_x_o      = out_q.words[0];
  assign size_y_o      = out_q.words[1];
  assign pixel_count_o = out_q.words[2];
  assign frame_id_o    = out_q.words[3];
  assign image_count_o = out_q.words[4];
  assign error_word_o  = out_q.words[5];
  assign pixel_o       = out_q.pixel;
  assign last_o        = out_q.last;

  `SHID_ASSERT(a_in_hold, in_v_q && in_stall_o |=> in_v_q && $stable(in_byte_q), "held item lost")
  `SHID_ASSERT(a_hunt_silent, fire && state_q.phase == shid_pkg::PH_HUNT |-> !res_valid, "hunt gave a result")
  `SHID_ASSERT(a_run_bound, state_q.sync_run < shid_pkg::SYNC_RUN_W'(shid_pkg::SYNC_LENGTH), "sync run overflow")

endmodule

FILE: dv/tb_sync_hunt_image_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_hunt_image_deframer
// Drives a byte stream of sync runs, headers and pixel data into the deframer,
// predicts every header, pixel and reject record in step with the accepted
// bytes, and compares each record that leaves the block. The pixel limit is
// reprogrammed over the APB port between phases with different idling.
// ----------------------------------------------------------------------------
module tb_sync_hunt_image_deframer;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_BYTES   = 80;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [2:0]  MAX_PIX_ADDR  = 3'd0;
  localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         byte_in_i   = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic signed [31:0] size_x_o;
  logic signed [31:0] size_y_o;
  logic signed [31:0] pixel_count_o;
  logic signed [31:0] frame_id_o;
  logic signed [31:0] image_count_o;
  logic signed [31:0] error_word_o;
  logic [15:0]        pixel_o;
  logic               last_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = 3'd0;
  logic [31:0]        pwdata      = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  // Mirror of the deframer state.
  shid_pkg::phase_e   hunt_phase = shid_pkg::PH_HUNT;
  int unsigned        z_run      = 0;
  logic [4:0]         hdr_idx    = 5'd0;
  logic [5:0][31:0]   hdr        = '0;
  logic [24:0]        pix_left   = '0;
  logic [7:0]         low_byte   = 8'h00;
  bit                 odd_byte   = 1'b0;
  logic [24:0]        max_pix    = shid_pkg::MAX_PIXELS_RST;

  logic [7:0]         stream_bytes[$];
  shid_pkg::result_t  awaited_records[$];
  int unsigned bytes_pushed  = 0;
  int unsigned errors        = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_arm      = 1'b0;
  bit          byte_taken    = 1'b0;

  sync_hunt_image_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .size_x_o      (size_x_o),
    .size_y_o      (size_y_o),
    .pixel_count_o (pixel_count_o),
    .frame_id_o    (frame_id_o),
    .image_count_o (image_count_o),
    .error_word_o  (error_word_o),
    .pixel_o       (pixel_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic deframe_byte(input logic [7:0] b);
    logic [4:0]        idx;
    logic [31:0]       cnt;
    shid_pkg::result_t rec;
    rec = '0;
    case (hunt_phase)
      shid_pkg::PH_HEAD: begin
        idx = (hdr_idx >= shid_pkg::HEAD_BYTES) ? 5'd0 : hdr_idx;
        hdr[idx[4:2]][8*idx[1:0] +: 8] = b;
        idx = idx + 5'd1;
        if (idx < shid_pkg::HEAD_BYTES) begin
          hdr_idx = idx;
        end else begin
          hdr_idx   = 5'd0;
          cnt       = hdr[2];
          rec.words = hdr;
          rec.last  = 1'b1;
          if (cnt[31] || cnt > {7'd0, max_pix}) begin
            rec.kind   = shid_pkg::KIND_REJECT;
            hunt_phase = shid_pkg::PH_HUNT;
            z_run      = 0;
          end else if (cnt == 32'd0) begin
            rec.kind   = shid_pkg::KIND_HEADER;
            hunt_phase = shid_pkg::PH_HUNT;
            z_run      = 0;
          end else begin
            rec.kind   = shid_pkg::KIND_HEADER;
            rec.last   = 1'b0;
            pix_left   = cnt[24:0];
            odd_byte   = 1'b0;
            hunt_phase = shid_pkg::PH_PIX;
          end
          awaited_records.push_back(rec);
        end
      end
      shid_pkg::PH_PIX: begin
        if (!odd_byte) begin
          low_byte = b;
          odd_byte = 1'b1;
        end else begin
          odd_byte = 1'b0;
          if (pix_left != 0) pix_left = pix_left - 25'd1;
          rec.kind  = shid_pkg::KIND_PIXEL;
          rec.pixel = {b, low_byte};
          rec.last  = (pix_left == 0);
          if (pix_left == 0) begin
            hunt_phase = shid_pkg::PH_HUNT;
            z_run      = 0;
          end
          awaited_records.push_back(rec);
        end
      end
      default: begin
        hunt_phase = shid_pkg::PH_HUNT;
        if (b == shid_pkg::SYNC_BYTE) begin
          z_run = z_run + 1;
          if (z_run >= shid_pkg::SYNC_LENGTH) begin
            z_run      = 0;
            hdr_idx    = 5'd0;
            hunt_phase = shid_pkg::PH_HEAD;
          end
        end else begin
          z_run = 0;
        end
      end
    endcase
  endtask

  task automatic check_record(input shid_pkg::result_t want, input shid_pkg::result_t got);
    bit bad;
    bad = (got.kind !== want.kind) || (got.pixel !== want.pixel) || (got.last !== want.last);
    for (int i = 0; i < shid_pkg::HEAD_WORDS; i++) bad |= (got.words[i] !== want.words[i]);
    if (bad) begin
      if (errors < REPORT_MAX) begin
        $display("Record mismatch: expected kind %0d words %h pixel %h last %b;",
                 want.kind, want.words, want.pixel, want.last,
                 " got kind %0d words %h pixel %h last %b",
                 got.kind, got.words, got.pixel, got.last);
      end
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    shid_pkg::result_t got;
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        byte_taken = 1'b1;
        deframe_byte(byte_in_i);
        stream_bytes.delete(0);
      end
      if (out_valid_o && !out_stall_i) begin
        got.kind  = shid_pkg::kind_e'(kind_o);
        got.words = {error_word_o, image_count_o, frame_id_o,
                     pixel_count_o, size_y_o, size_x_o};
        got.pixel = pixel_o;
        got.last  = last_o;
        if (awaited_records.size() == 0) begin
          if (errors < REPORT_MAX) begin
            $display("Unexpected record: kind %0d words %h pixel %h last %b",
                     got.kind, got.words, got.pixel, got.last);
          end
          errors++;
        end else begin
          check_record(awaited_records.pop_front(), got);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || byte_taken) begin
      if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_valid_i <= 1'b1;
        byte_in_i  <= stream_bytes[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_max_reg();
    logic [31:0] v;
    apb_xfer(1'b0, MAX_PIX_ADDR, 32'd0, v);
    if (v !== {7'd0, max_pix}) begin
      if (errors < REPORT_MAX) begin
        $display("Pixel limit readback: expected %h, got %h", {7'd0, max_pix}, v);
      end
      errors++;
    end
  endtask

  task automatic wait_idle();
    while (stream_bytes.size() != 0 || awaited_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_max(input logic [2:0] addr, input logic [31:0] v);
    logic [31:0] unused;
    wait_idle();
    apb_xfer(1'b1, addr, v, unused);
    if (addr == MAX_PIX_ADDR) max_pix = v[24:0];
    check_max_reg();
  endtask

  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_frame(input logic [31:0] w [6], input int unsigned cut = 24);
    repeat (shid_pkg::SYNC_LENGTH) push_byte(shid_pkg::SYNC_BYTE);
    for (int i = 0; i < cut; i++) push_byte(w[i/4][8*(i%4) +: 8]);
  endtask

  task automatic push_pixel_bytes(input int unsigned n);
    repeat (2*n) push_byte(8'($urandom));
  endtask

  task automatic gen_frame();
    logic [31:0] w [6];
    logic [31:0] cnt;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned cut;
    repeat ($urandom_range(0, 8)) begin
      push_byte(($urandom_range(0, 3) == 0) ? shid_pkg::SYNC_BYTE : 8'($urandom));
    end
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, shid_pkg::SYNC_LENGTH - 1)) push_byte(shid_pkg::SYNC_BYTE);
      b = 8'($urandom);
      if (b == shid_pkg::SYNC_BYTE) b = 8'h00;
      push_byte(b);
    end
    foreach (w[i]) w[i] = $urandom;
    if ($urandom_range(0, 9) == 0) w[0] = {4{shid_pkg::SYNC_BYTE}};
    pick = $urandom_range(0, 99);
    if (pick < 10) cnt = 32'd0;
    else if (pick < 60) cnt = $urandom_range(1, 12);
    else if (pick < 70) cnt = (max_pix <= 40) ? 32'(max_pix) : $urandom_range(1, 12);
    else if (pick < 80) cnt = 32'(max_pix) + 32'd1;
    else if (pick < 90) cnt = {1'b1, 31'($urandom)};
    else cnt = $urandom | 32'h0200_0000;
    w[2] = cnt;
    // A cut header leaves the rest to be filled by whatever follows.
    cut = ($urandom_range(0, 99) < 5) ? $urandom_range(12, 23) : 24;
    push_frame(w, cut);
    if (cut == 24 && !cnt[31] && cnt != 0 && cnt <= {7'd0, max_pix}) push_pixel_bytes(cnt);
  endtask

  initial begin
    logic [31:0] v;
    int unsigned mark;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_max_reg();
    hold_arm = 1'b1;

    push_frame('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF});
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    push_frame('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    repeat (shid_pkg::SYNC_LENGTH - 1) push_byte(shid_pkg::SYNC_BYTE);
    push_byte(8'h00);
    push_frame('{{4{shid_pkg::SYNC_BYTE}}, 32'd640, 32'd1, {4{shid_pkg::SYNC_BYTE}},
                 32'd7, 32'd0});
    push_byte(shid_pkg::SYNC_BYTE);
    push_byte(shid_pkg::SYNC_BYTE);
    push_frame('{32'd1, 32'd2, 32'h8000_0000, 32'd3, 32'd4, 32'd5});
    push_frame('{32'd6, 32'd7, 32'h7FFF_FFFF, 32'd8, 32'd9, 32'h8000_0000});
    push_frame('{32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1});

    program_max(UNMAPPED_ADDR, 32'd0);
    program_max(MAX_PIX_ADDR, 32'd3);
    push_frame('{32'd10, 32'd20, 32'd3, 32'd30, 32'd40, 32'd50});
    push_pixel_bytes(3);
    push_frame('{32'd11, 32'd21, 32'd4, 32'd31, 32'd41, 32'd51});

    program_max(MAX_PIX_ADDR, 32'd0);
    push_frame('{32'd12, 32'd22, 32'd0, 32'd32, 32'd42, 32'd52});
    push_frame('{32'd13, 32'd23, 32'd1, 32'd33, 32'd43, 32'd53});

    program_max(MAX_PIX_ADDR, 32'h0100_0000);
    push_frame('{32'd14, 32'd24, 32'h0100_0001, 32'd34, 32'd44, 32'd54});
    push_frame('{32'd15, 32'd25, 32'd5, 32'd35, 32'd45, 32'd55});
    push_pixel_bytes(5);

    program_max(MAX_PIX_ADDR, 32'hFFFF_FFFF);
    push_frame('{32'd16, 32'd26, 32'h0200_0000, 32'd36, 32'd46, 32'd56});
    push_frame('{32'd17, 32'd27, 32'd2, 32'd37, 32'd47, 32'd57});
    push_pixel_bytes(2);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       v = 32'h0100_0000;
        1:       v = 32'd0;
        2:       v = $urandom_range(1, 30);
        default: v = 32'(shid_pkg::MAX_PIXELS_RST);
      endcase
      program_max(MAX_PIX_ADDR, v);
      case (mode)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 58;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 58;
        end
        default: begin
          src_idle_pct  = 21;
          snk_stall_pct = 21;
        end
      endcase
      mark = bytes_pushed;
      while (bytes_pushed - mark < PHASE_BYTES) gen_frame();
    end

    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
